@@ rtl/ahist_pkg.sv @@
// ----------------------------------------------------------------------------
// ahist_pkg
// Shared constants and types for the auto-ranging histogram.
// ----------------------------------------------------------------------------
package ahist_pkg;

    localparam int NUM_BINS    = 20;
    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 32;

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int Q_W    = $clog2(NUM_BINS + 1);
    localparam int STEP_W = $clog2(Q_W + 1);
    localparam int PROD_W = SAMPLE_BITS + Q_W;

    localparam int OUT_FIELDS_W = BIN_W + 2 * CNT_W + 2 * SAMPLE_BITS;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SAMPLES);

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_FETCH,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_EMPTY
    } state_t;

endpackage

@@ rtl/ahist_ram.sv @@
// ----------------------------------------------------------------------------
// ahist_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ahist_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/ahist_bin_div.sv @@
// ----------------------------------------------------------------------------
// ahist_bin_div
// Iterative bin quotient: floor((v-min)*NUM_BINS/span), clamped, one bit/cycle.
// ----------------------------------------------------------------------------
module ahist_bin_div
    import ahist_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] min_val,
    input  logic signed [SAMPLE_BITS-1:0] max_val,
    output logic                          done,
    output logic [BIN_W-1:0]              q
);

    logic                   busy_reg,  busy_next;
    logic                   scale_reg, scale_next;
    logic                   done_reg,  done_next;
    logic [STEP_W-1:0]      k_reg,     k_next;
    logic [SAMPLE_BITS-1:0] diff_reg,  diff_next;
    logic [SAMPLE_BITS-1:0] span_reg,  span_next;
    logic [PROD_W-1:0]      rem_reg,   rem_next;
    logic [Q_W-1:0]         q_reg,     q_next;
    logic [PROD_W-1:0]      divisor;
    logic [PROD_W:0]        trial;

    assign divisor = PROD_W'(span_reg) << k_reg;
    assign trial   = {1'b0, rem_reg} - {1'b0, divisor};

    always_comb
    begin
        busy_next  = busy_reg;
        scale_next = 1'b0;
        done_next  = 1'b0;
        k_next     = k_reg;
        diff_next  = diff_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            scale_next = 1'b1;
            diff_next  = SAMPLE_BITS'(sample - min_val);
            span_next  = SAMPLE_BITS'(max_val - min_val);
            q_next     = '0;
        end
        else if (scale_reg)
        begin
            rem_next = PROD_W'(diff_reg) * PROD_W'(NUM_BINS);
            k_next   = STEP_W'(Q_W - 1);
        end
        else if (busy_reg)
        begin
            if (!trial[PROD_W])
            begin
                rem_next = trial[PROD_W-1:0];
                q_next   = q_reg | (Q_W'(1) << k_reg);
            end
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            scale_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            scale_reg <= scale_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        diff_reg <= diff_next;
        span_reg <= span_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;

    always_comb
    begin
        if (span_reg == '0)
        begin
            q = '0;
        end
        else if (q_reg > Q_W'(NUM_BINS - 1))
        begin
            q = BIN_LAST;
        end
        else
        begin
            q = BIN_W'(q_reg);
        end
    end

endmodule

@@ rtl/auto_range_histogram.sv @@
// ----------------------------------------------------------------------------
// auto_range_histogram
// Min/max auto-ranging 20-bin histogram over a set of Q16.16 samples.
// ----------------------------------------------------------------------------
// Input stream: tdata = sample (Q16.16), tuser = finite flag, tlast = end of set.
// Finite samples are written to a 4096-entry sample RAM while count, min and
// max are tracked; one transaction per cycle is taken while loading. Samples
// past 4096 are dropped and reported as store overflow.
// On tlast the input stalls (tready low) and a binning pass reads each stored
// sample back, runs it through the iterative bin divider and increments the
// bin counter RAM with a read-modify-write. Then the 20 bin results go out,
// each read from the bin counter RAM into the output register; each counter
// is zeroed as it is read. An empty set gives one result with set_empty.
// Results sit in an output register; a stalled receiver only holds that
// register and the sequencer, and loading of the next set starts as soon as
// the last result is in the output register.
// After reset the block zeroes every entry of the bin counter RAM before
// tready rises.
// ----------------------------------------------------------------------------
module auto_range_histogram
    import ahist_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // sample_value
    input  logic                  s_axis_tuser,  // sample_finite
    input  logic                  s_axis_tlast,  // last_sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // bin_index, bin_count, sample_count,
                                                 // min_seen, max_seen, zero pad
    output logic [1:0]            m_axis_tuser,  // set_empty, store_overflow
    output logic                  m_axis_tlast   // last_result
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              idx_reg,   idx_next;
    logic [BIN_W-1:0]              bin_reg,   bin_next;
    logic signed [SAMPLE_BITS-1:0] min_reg,   min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg,   max_next;
    logic                          ovf_reg,   ovf_next;
    logic                          ovalid_reg, ovalid_next;

    logic [OUT_DATA_W-1:0] odata_reg, odata_next;
    logic [1:0]            ouser_reg, ouser_next;
    logic                  olast_reg, olast_next;

    logic signed [SAMPLE_BITS-1:0] in_value;
    logic in_acc, take, full, out_free, out_load, set_done;

    logic                   store_we, store_re;
    logic [ADDR_W-1:0]      store_waddr, store_raddr;
    logic [SAMPLE_BITS-1:0] store_rdata;

    logic              bins_we, bins_re;
    logic [BIN_W-1:0]  bins_waddr, bins_raddr;
    logic [CNT_W-1:0]  bins_wdata, bins_rdata;

    logic             div_start, div_done;
    logic [BIN_W-1:0] div_q;

    assign in_value = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign full     = (count_reg == CNT_FULL);
    assign take     = in_acc && s_axis_tuser && !full;
    assign out_free = !ovalid_reg || m_axis_tready;

    ahist_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (in_value),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    ahist_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (bins_we),
        .waddr (bins_waddr),
        .wdata (bins_wdata),
        .re    (bins_re),
        .raddr (bins_raddr),
        .rdata (bins_rdata)
    );

    ahist_bin_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .sample  ($signed(store_rdata)),
        .min_val (min_reg),
        .max_val (max_reg),
        .done    (div_done),
        .q       (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (bin_reg == BIN_LAST)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    if (count_reg == '0 && !take)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:   state_next = ST_LAUNCH;
            ST_LAUNCH:  state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_BUMP_RD;
                end
            end
            ST_BUMP_RD: state_next = ST_BUMP_WR;
            ST_BUMP_WR:
            begin
                if (idx_reg + 1'b1 == count_reg)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_OUT_RD:  state_next = ST_OUT_LD;
            ST_OUT_LD:
            begin
                if (out_free)
                begin
                    state_next = (bin_reg == BIN_LAST) ? ST_LOAD : ST_OUT_RD;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:    state_next = ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        store_re      = 1'b0;
        div_start     = 1'b0;
        bins_re       = 1'b0;
        bins_we       = 1'b0;
        bins_raddr    = div_q;
        bins_waddr    = bin_reg;
        bins_wdata    = '0;
        out_load      = 1'b0;
        set_done      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                bins_we = 1'b1;
            end
            ST_LOAD:
            begin
                s_axis_tready = 1'b1;
            end
            ST_FETCH:
            begin
                store_re = 1'b1;
            end
            ST_LAUNCH:
            begin
                div_start = 1'b1;
            end
            ST_BUMP_RD:
            begin
                bins_re = 1'b1;
            end
            ST_BUMP_WR:
            begin
                bins_we    = 1'b1;
                bins_waddr = div_q;
                bins_wdata = bins_rdata + 1'b1;
            end
            ST_OUT_RD:
            begin
                bins_re    = 1'b1;
                bins_raddr = bin_reg;
            end
            ST_OUT_LD:
            begin
                bins_we  = out_free;
                out_load = out_free;
                set_done = out_free && (bin_reg == BIN_LAST);
            end
            ST_EMPTY:
            begin
                out_load = out_free;
                set_done = out_free;
            end
            default:
            begin
                bins_we = 1'b0;
            end
        endcase
    end

    assign store_we    = take;
    assign store_waddr = count_reg[ADDR_W-1:0];
    assign store_raddr = idx_reg[ADDR_W-1:0];

    // set state and counters
    always_comb
    begin
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        bin_next   = bin_reg;
        if (take)
        begin
            count_next = count_reg + 1'b1;
            if (in_value < min_reg)
            begin
                min_next = in_value;
            end
            if (in_value > max_reg)
            begin
                max_next = in_value;
            end
        end
        if (in_acc && s_axis_tuser && full)
        begin
            ovf_next = 1'b1;
        end
        if (set_done)
        begin
            count_next = '0;
            min_next   = SMAX;
            max_next   = SMIN;
            ovf_next   = 1'b0;
        end
        if (state_reg == ST_LOAD)
        begin
            idx_next = '0;
        end
        else if (state_reg == ST_BUMP_WR)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (state_reg == ST_CLEAR || (state_reg == ST_OUT_LD && out_free))
        begin
            bin_next = (bin_reg == BIN_LAST) ? '0 : bin_reg + 1'b1;
        end
    end

    // output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        olast_next  = olast_reg;
        if (out_load)
        begin
            ovalid_next = 1'b1;
            if (state_reg == ST_EMPTY)
            begin
                odata_next = '0;
                ouser_next = {ovf_reg, 1'b1};
                olast_next = 1'b1;
            end
            else
            begin
                odata_next = OUT_DATA_W'({max_reg, min_reg, count_reg, bins_rdata, bin_reg});
                ouser_next = {ovf_reg, 1'b0};
                olast_next = (bin_reg == BIN_LAST);
            end
        end
        else if (m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            count_reg  <= '0;
            min_reg    <= SMAX;
            max_reg    <= SMIN;
            ovf_reg    <= 1'b0;
            idx_reg    <= '0;
            bin_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            ovf_reg    <= ovf_next;
            idx_reg    <= idx_next;
            bin_reg    <= bin_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;
    assign m_axis_tlast  = olast_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("sample count beyond store depth");

    a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && olast_reg && !ouser_reg[0]) |->
        (odata_reg[BIN_W-1:0] == BIN_LAST))
        else $error("final result is not the last bin");

    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (min_reg <= max_reg))
        else $error("binning with min above max");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUMP_RD) |-> (idx_reg < count_reg))
        else $error("binning index past sample count");

endmodule

@@ verif/histogram_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_checker
// Monitors both streams of auto_range_histogram. It rebuilds each sample set
// from the accepted input transactions, bins the set on the closing
// transaction and checks every result transaction against that prediction.
// ----------------------------------------------------------------------------
module histogram_checker
    import ahist_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // sample_value
    input  logic                  s_axis_tuser,  // sample_finite
    input  logic                  s_axis_tlast,  // last_sample
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // bin_index, bin_count, sample_count,
                                                 // min_seen, max_seen, zero pad
    input  logic [1:0]            m_axis_tuser,  // set_empty, store_overflow
    input  logic                  m_axis_tlast,  // last_result
    output int                    pending,
    output int                    fail_count
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [BIN_W-1:0]              bin;
        logic [CNT_W-1:0]              hits;
        logic [CNT_W-1:0]              total;
        logic signed [SAMPLE_BITS-1:0] lo;
        logic signed [SAMPLE_BITS-1:0] hi;
        logic                          empty;
        logic                          dropped;
        logic                          closing;
    } bin_report_t;

    bin_report_t                   expected_bins[$];
    logic signed [SAMPLE_BITS-1:0] set_samples[$];
    logic signed [SAMPLE_BITS-1:0] set_min;
    logic signed [SAMPLE_BITS-1:0] set_max;
    logic                          set_dropped;
    int                            mismatches;

    function automatic void forget_set();
        set_samples.delete();
        set_min     = SMAX;
        set_max     = SMIN;
        set_dropped = 1'b0;
    endfunction

    always @(posedge clk)
    begin : watch
        bin_report_t      seen;
        bin_report_t      want;
        logic [CNT_W-1:0] hits [NUM_BINS];
        longint           lo;
        longint           span;
        longint           d;
        longint           b;
        int               k;
        if (!rst_n)
        begin
            expected_bins.delete();
            forget_set();
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.bin     = m_axis_tdata[BIN_W-1:0];
                seen.hits    = m_axis_tdata[BIN_W +: CNT_W];
                seen.total   = m_axis_tdata[BIN_W+CNT_W +: CNT_W];
                seen.lo      = m_axis_tdata[BIN_W+2*CNT_W +: SAMPLE_BITS];
                seen.hi      = m_axis_tdata[BIN_W+2*CNT_W+SAMPLE_BITS +: SAMPLE_BITS];
                seen.empty   = m_axis_tuser[0];
                seen.dropped = m_axis_tuser[1];
                seen.closing = m_axis_tlast;
                if (expected_bins.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: bin %0d count %0d total %0d last %0b",
                                 seen.bin, seen.hits, seen.total, seen.closing);
                end
                else
                begin
                    want = expected_bins.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $write("result mismatch: expected bin %0d count %0d total %0d",
                                   want.bin, want.hits, want.total);
                            $display(" min %0d max %0d empty %0b ovf %0b last %0b",
                                     want.lo, want.hi, want.empty, want.dropped,
                                     want.closing);
                            $write("                 actual   bin %0d count %0d total %0d",
                                   seen.bin, seen.hits, seen.total);
                            $display(" min %0d max %0d empty %0b ovf %0b last %0b",
                                     seen.lo, seen.hi, seen.empty, seen.dropped,
                                     seen.closing);
                        end
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser)
                begin
                    if (set_samples.size() < MAX_SAMPLES)
                    begin
                        set_samples = {set_samples, $signed(s_axis_tdata)};
                        if ($signed(s_axis_tdata) < set_min)
                            set_min = s_axis_tdata;
                        if ($signed(s_axis_tdata) > set_max)
                            set_max = s_axis_tdata;
                    end
                    else
                        set_dropped = 1'b1;
                end
                if (s_axis_tlast)
                begin
                    want.dropped = set_dropped;
                    if (set_samples.size() == 0)
                    begin
                        want.bin     = '0;
                        want.hits    = '0;
                        want.total   = '0;
                        want.lo      = '0;
                        want.hi      = '0;
                        want.empty   = 1'b1;
                        want.closing = 1'b1;
                        expected_bins = {expected_bins, want};
                    end
                    else
                    begin
                        for (k = 0; k < NUM_BINS; k++)
                            hits[k] = '0;
                        lo   = set_min;
                        span = longint'(set_max) - lo;
                        for (k = 0; k < set_samples.size(); k++)
                        begin
                            b = 0;
                            if (span > 0)
                            begin
                                d = longint'(set_samples[k]) - lo;
                                b = (d * NUM_BINS) / span;
                                if (b > NUM_BINS - 1)
                                    b = NUM_BINS - 1;
                            end
                            hits[b] = hits[b] + 1'b1;
                        end
                        for (k = 0; k < NUM_BINS; k++)
                        begin
                            want.bin     = BIN_W'(k);
                            want.hits    = hits[k];
                            want.total   = CNT_W'(set_samples.size());
                            want.lo      = set_min;
                            want.hi      = set_max;
                            want.empty   = 1'b0;
                            want.closing = (k == NUM_BINS - 1);
                            expected_bins = {expected_bins, want};
                        end
                    end
                    forget_set();
                end
            end
        end
        pending    <= expected_bins.size();
        fail_count <= mismatches;
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample sets into auto_range_histogram with random gaps on the input
// and random stalls on the output: edge-case sets first, then a store-full
// set, then random sets of varied spread. histogram_checker does the checking.
// ----------------------------------------------------------------------------
module testbench;
    import ahist_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SAMPLE_TARGET = 500;
    localparam int DRAIN_CYCLES  = 200;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_FLAT,
        SPREAD_EXTREME,
        SPREAD_TINY,
        SPREAD_WIDE
    } spread_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    int                    pending;
    int                    fail_count;
    int unsigned           cycles        = 0;
    int unsigned           finite_sent   = 0;
    bit                    tx_steady     = 1'b0;

    auto_range_histogram dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    histogram_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL auto_range_histogram");
            $finish;
        end
    end

    // result sink: random stall before each result, with occasional steady runs
    initial
    begin : result_sink
        int unsigned hold;
        bit          rx_steady;
        rx_steady = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_steady = !rx_steady;
            hold = rx_steady ? 0 : $urandom_range(0, 11);
            if (hold != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_sample(input logic [31:0] value, input logic finite,
                               input logic closing);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= 1'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= finite;
        s_axis_tlast  <= closing;
        do @(posedge clk); while (!s_axis_tready);
        if (finite)
            finite_sent++;
    endtask

    task automatic send_random_set();
        int unsigned n;
        int unsigned i;
        spread_t     spread;
        logic [31:0] base;
        logic [31:0] value;
        logic        finite;
        bit          no_finite;
        if ($urandom_range(0, 7) == 0)
            tx_steady = !tx_steady;
        n         = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64)
                                                : $urandom_range(1, 12);
        spread    = spread_t'($urandom_range(0, 5));
        base      = $urandom;
        no_finite = ($urandom_range(0, 11) == 0);
        for (i = 0; i < n; i++)
        begin
            case (spread)
                SPREAD_FULL:    value = $urandom;
                SPREAD_NARROW:  value = base + $urandom_range(0, 40);
                SPREAD_FLAT:    value = base;
                SPREAD_EXTREME:
                    case ($urandom_range(0, 4))
                        0:       value = SMIN;
                        1:       value = SMAX;
                        2:       value = '0;
                        3:       value = '1;
                        default: value = 32'd1;
                    endcase
                SPREAD_TINY:    value = base + $urandom_range(0, 2);
                default:        value = base + ($urandom & 32'h000F_FFFF);
            endcase
            finite = !no_finite && ($urandom_range(0, 7) != 0);
            send_sample(value, finite, i == n - 1);
        end
    endtask

    initial
    begin : stimulus
        int unsigned i;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty set closed by a skipped sample
        send_sample(32'h1234_5678, 1'b0, 1'b1);
        // lone sample, zero span
        send_sample(SMIN, 1'b1, 1'b1);
        // full signed range
        send_sample(SMIN, 1'b1, 1'b0);
        send_sample(SMAX, 1'b1, 1'b0);
        send_sample('0,   1'b1, 1'b1);
        // span of one LSB
        send_sample(32'd5, 1'b1, 1'b0);
        send_sample(32'd6, 1'b1, 1'b1);
        // all samples equal
        send_sample(-32'sd7, 1'b1, 1'b0);
        send_sample(-32'sd7, 1'b1, 1'b0);
        send_sample(-32'sd7, 1'b1, 1'b1);
        // set closed by a skipped sample
        send_sample(32'd1, 1'b1, 1'b0);
        send_sample(32'd2, 1'b1, 1'b0);
        send_sample(32'd3, 1'b1, 1'b0);
        send_sample(SMAX,  1'b0, 1'b1);
        // skipped extremes must not move min or max
        send_sample(-32'sd100, 1'b1, 1'b0);
        send_sample(SMIN,      1'b0, 1'b0);
        send_sample(SMAX,      1'b0, 1'b0);
        send_sample(32'd100,   1'b1, 1'b1);
        // empty set of several skipped samples
        send_sample('0, 1'b0, 1'b0);
        send_sample('1, 1'b0, 1'b1);

        // fill the store, then two extreme samples that must be dropped
        tx_steady = 1'b1;
        for (i = 0; i < MAX_SAMPLES; i++)
            send_sample(32'($urandom_range(0, 2000)) - 32'd1000, 1'b1, 1'b0);
        send_sample(SMIN, 1'b1, 1'b0);
        send_sample(SMAX, 1'b1, 1'b1);
        tx_steady = 1'b0;

        finite_sent = 0;
        while (finite_sent < SAMPLE_TARGET)
            send_random_set();

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS auto_range_histogram");
        else
            $display("FAIL auto_range_histogram");
        $finish;
    end

endmodule
